// ===== src/lpfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length prefixed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 17;
  localparam int unsigned HeaderN  = 3;

  localparam logic [ByteW-1:0]  StartByte   = 8'hC0;
  localparam logic [CountW-1:0] MaxBodyRst  = 17'd1024;

  typedef enum logic [1:0] {
    ST_DISCARD = 2'd0,
    ST_BYTE    = 2'd1,
    ST_LAST    = 2'd2,
    ST_LEN_ERR = 2'd3
  } lpfr_status_e;

  typedef struct packed {
    lpfr_status_e      status;
    logic [ByteW-1:0]  frame_byte;
    logic [CountW-1:0] byte_offset;
  } lpfr_result_t;

endpackage

`default_nettype wire

// ===== src/lpfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// lpfr_in_stage
// Input register for received bytes, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_in_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [lpfr_pkg::ByteW-1:0]  rx_byte_i,
  input  wire logic                        advance_i,
  output logic                             valid_o,
  output logic [lpfr_pkg::ByteW-1:0]       byte_o
);
  import lpfr_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== src/lpfr_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// lpfr_frame_fsm
// Frame tracking state, length check and per-byte result decode.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_frame_fsm (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [lpfr_pkg::CountW-1:0] max_body_i,
  input  wire logic                        advance_i,
  input  wire logic [lpfr_pkg::ByteW-1:0]  byte_i,
  output lpfr_pkg::lpfr_result_t           result_o
);
  import lpfr_pkg::*;

  logic              in_frame_q, in_frame_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [ByteW-1:0]  len_hi_q, len_hi_d;
  logic [CountW-1:0] body;

  assign body = {1'b0, len_hi_q, byte_i} + CountW'(1);

  always_comb begin
    in_frame_d           = in_frame_q;
    count_d              = count_q;
    remain_d             = remain_q;
    len_hi_d             = len_hi_q;
    result_o.status      = ST_BYTE;
    result_o.frame_byte  = byte_i;
    result_o.byte_offset = count_q;
    if (!in_frame_q) begin
      result_o.byte_offset = '0;
      if (byte_i == StartByte) begin
        in_frame_d = 1'b1;
        count_d    = CountW'(1);
      end else begin
        result_o.status     = ST_DISCARD;
        result_o.frame_byte = '0;
      end
    end else begin
      count_d = count_q + CountW'(1);
      if (count_q == CountW'(1)) begin
        len_hi_d = byte_i;
      end else if (count_q == CountW'(2)) begin
        if (body > max_body_i) begin
          result_o.status = ST_LEN_ERR;
          in_frame_d      = 1'b0;
          count_d         = '0;
          remain_d        = '0;
        end else begin
          remain_d = body;
        end
      end else if (count_q >= CountW'(HeaderN)) begin
        if (remain_q <= CountW'(1)) begin
          result_o.status = ST_LAST;
          in_frame_d      = 1'b0;
          count_d         = '0;
          remain_d        = '0;
        end else begin
          remain_d = remain_q - CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      remain_q   <= '0;
      len_hi_q   <= '0;
    end else if (advance_i) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      remain_q   <= remain_d;
      len_hi_q   <= len_hi_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/lpfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// lpfr_out_stage
// Result register holding one item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_out_stage (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_valid_i,
  output logic                         load_ready_o,
  input  wire lpfr_pkg::lpfr_result_t  result_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output lpfr_pkg::lpfr_result_t       result_o
);
  import lpfr_pkg::*;

  logic         valid_q, valid_d;
  lpfr_result_t result_q;

  assign load_ready_o = !valid_q || out_ready_i;
  assign valid_d      = (load_valid_i && load_ready_o) || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== src/length_prefixed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Hunts for the start byte, reads a 16-bit big-endian length and tags every
// frame byte with its offset, status and length error drop.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_max_body_length_i[16:0]
//  in      | in  | in_valid_i/in_ready_o   | rx_byte_i[7:0]
//  out     | out | out_valid_o/out_ready_i | status_o, frame_byte_o, byte_offset_o
//
//  one item per cycle unless the sink stalls; an accepted byte enters
//  the input register, which drains into the result register when that
//  slot is free, and frame state updates on that transfer
//  a stalled sink holds one result and one more item in the input register
//  reset clears all valid flags, frame state and sets the limit to 1024
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_receiver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [lpfr_pkg::CountW-1:0] cfg_max_body_length_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [lpfr_pkg::ByteW-1:0]  rx_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       status_o,
  output logic [lpfr_pkg::ByteW-1:0]       frame_byte_o,
  output logic [lpfr_pkg::CountW-1:0]      byte_offset_o
);
  import lpfr_pkg::*;

  logic [CountW-1:0] max_len_q;
  logic              stage_valid;
  logic [ByteW-1:0]  stage_byte;
  logic              slot_free;
  logic              advance;
  lpfr_result_t      next_result;
  lpfr_result_t      out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxBodyRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_max_body_length_i;
    end
  end

  assign advance = stage_valid && slot_free;

  lpfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  lpfr_frame_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_body_i (max_len_q),
    .advance_i  (advance),
    .byte_i     (stage_byte),
    .result_o   (next_result)
  );

  lpfr_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (stage_valid),
    .load_ready_o (slot_free),
    .result_i     (next_result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (out_result)
  );

  assign status_o      = out_result.status;
  assign frame_byte_o  = out_result.frame_byte;
  assign byte_offset_o = out_result.byte_offset;

endmodule

`default_nettype wire

// ===== src/lpfr_checker.sv =====
// ----------------------------------------------------------------------------
// lpfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [7:0]  frame_byte_o,
  input wire logic [16:0] byte_offset_o
);
  import lpfr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(frame_byte_o) && $stable(byte_offset_o))
    else $error("result changed while stalled");

  a_discard_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DISCARD |-> frame_byte_o == '0 && byte_offset_o == '0)
    else $error("discarded item carries data");

  a_start_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BYTE && byte_offset_o == '0 |-> frame_byte_o == StartByte)
    else $error("frame opened without start byte");

  a_err_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LEN_ERR |-> byte_offset_o == 17'd2)
    else $error("length error away from second length byte");

  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LAST |-> byte_offset_o >= 17'd3)
    else $error("frame ended inside header");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .frame_byte_o  (frame_byte_o),
  .byte_offset_o (byte_offset_o)
);

`default_nettype wire
